// ----- src/pbdc_pkg.sv -----
package pbdc_pkg;

  localparam int TIME_W     = 24;
  localparam int LOG_SLOTS  = 512;
  localparam int SLOT_CNT_W = 10;
  localparam int SLOT_IDX_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

  localparam logic [TIME_W-1:0] QUIET_TIMEOUT_RST = 24'd164;
  localparam logic [TIME_W-1:0] MIN_LENGTH_RST    = 24'd2785;
  localparam logic [TIME_W-1:0] MAX_LENGTH_RST    = 24'd9994;

  typedef struct packed {
    logic [TIME_W-1:0] quiet_timeout;
    logic [TIME_W-1:0] min_length;
    logic [TIME_W-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]     duration;
    logic                  accepted;
    logic                  logged;
    logic [SLOT_IDX_W-1:0] slot_index;
  } result_t;

endpackage

// ----- src/pbdc_cfg_regs.sv -----
module pbdc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [pbdc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [pbdc_pkg::TIME_W-1:0]    wr_data,
  output pbdc_pkg::cfg_t                 cfg
);

  pbdc_pkg::cfg_t cfg_r;
  pbdc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        pbdc_pkg::CFG_QUIET_TIMEOUT: cfg_nxt.quiet_timeout = wr_data;
        pbdc_pkg::CFG_MIN_LENGTH:    cfg_nxt.min_length    = wr_data;
        pbdc_pkg::CFG_MAX_LENGTH:    cfg_nxt.max_length    = wr_data;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quiet_timeout <= pbdc_pkg::QUIET_TIMEOUT_RST;
      cfg_r.min_length    <= pbdc_pkg::MIN_LENGTH_RST;
      cfg_r.max_length    <= pbdc_pkg::MAX_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/pbdc_burst_core.sv -----
module pbdc_burst_core (
  input  logic                clk,
  input  logic                rst_n,
  input  pbdc_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_edge_seen,
  input  logic                res_free,
  output logic                res_push,
  output pbdc_pkg::result_t   res
);

  logic                            s1_valid_r, s1_valid_nxt;
  logic                            s1_edge_r;
  logic [pbdc_pkg::TIME_W-1:0]     tick_time_r, tick_time_nxt;
  logic                            in_burst_r, in_burst_nxt;
  logic [pbdc_pkg::TIME_W-1:0]     burst_start_r, burst_start_nxt;
  logic [pbdc_pkg::TIME_W-1:0]     burst_end_r, burst_end_nxt;
  logic [pbdc_pkg::TIME_W-1:0]     quiet_count_r, quiet_count_nxt;
  logic [pbdc_pkg::SLOT_CNT_W-1:0] slots_used_r, slots_used_nxt;

  logic [pbdc_pkg::TIME_W-1:0] quiet_inc;
  logic [pbdc_pkg::TIME_W-1:0] dur;
  logic                        close;
  logic                        slot_free;
  logic                        fire;

  assign quiet_inc = quiet_count_r + pbdc_pkg::TIME_W'(1);
  assign close     = s1_valid_r && !s1_edge_r && in_burst_r &&
                     (quiet_inc >= cfg.quiet_timeout);
  assign dur       = burst_end_r - burst_start_r;
  assign slot_free = slots_used_r < pbdc_pkg::SLOT_CNT_W'(pbdc_pkg::LOG_SLOTS);
  assign fire      = s1_valid_r && (!close || res_free);
  assign in_ready  = !s1_valid_r || fire;
  assign res_push  = fire && close;

  always_comb begin
    res.duration   = dur;
    res.accepted   = (dur > cfg.min_length) && (dur < cfg.max_length);
    res.logged     = slot_free;
    res.slot_index = slot_free ? slots_used_r[pbdc_pkg::SLOT_IDX_W-1:0] : '0;
  end

  always_comb begin
    s1_valid_nxt    = (in_valid && in_ready) || (s1_valid_r && !fire);
    tick_time_nxt   = tick_time_r;
    in_burst_nxt    = in_burst_r;
    burst_start_nxt = burst_start_r;
    burst_end_nxt   = burst_end_r;
    quiet_count_nxt = quiet_count_r;
    slots_used_nxt  = slots_used_r;
    if (fire) begin
      tick_time_nxt = tick_time_r + pbdc_pkg::TIME_W'(1);
      if (s1_edge_r) begin
        burst_end_nxt   = tick_time_r;
        quiet_count_nxt = '0;
        if (!in_burst_r) begin
          burst_start_nxt = tick_time_r;
          in_burst_nxt    = 1'b1;
        end
      end else if (in_burst_r) begin
        quiet_count_nxt = quiet_inc;
        if (close) begin
          in_burst_nxt    = 1'b0;
          burst_start_nxt = '0;
          burst_end_nxt   = '0;
          quiet_count_nxt = '0;
          if (slot_free) begin
            slots_used_nxt = slots_used_r + pbdc_pkg::SLOT_CNT_W'(1);
          end
        end
      end
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_edge_r <= in_edge_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      tick_time_r   <= '0;
      in_burst_r    <= 1'b0;
      burst_start_r <= '0;
      burst_end_r   <= '0;
      quiet_count_r <= '0;
      slots_used_r  <= '0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      tick_time_r   <= tick_time_nxt;
      in_burst_r    <= in_burst_nxt;
      burst_start_r <= burst_start_nxt;
      burst_end_r   <= burst_end_nxt;
      quiet_count_r <= quiet_count_nxt;
      slots_used_r  <= slots_used_nxt;
    end
  end

endmodule

// ----- src/pbdc_out_reg.sv -----
module pbdc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_push,
  input  pbdc_pkg::result_t res,
  output logic              res_free,
  output logic              out_valid,
  input  logic              out_ready,
  output pbdc_pkg::result_t out_res
);

  logic              out_valid_r, out_valid_nxt;
  pbdc_pkg::result_t out_res_r;

  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ----- src/pulse_burst_duration_classifier_top.sv -----
// Pulse burst duration classifier. Each input word is one timebase tick with an
// edge flag; a 24-bit tick counter stamps the first and last edge of a burst, and
// once quiet_timeout edge-free ticks pass the burst closes and one result word
// carries its duration (mod 2^24), the min/max window flag and a log slot while
// any of the 512 slots remain. One tick is taken per clock cycle unless a result
// waits on a busy output register; a result passes through one input register and
// one output register. The user is to write configuration registers via the cfg
// port only while the block is idle, not enforced here; cfg_ready is always high.
module pulse_burst_duration_classifier_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbdc_pkg::TIME_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_edge_seen,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pbdc_pkg::TIME_W-1:0]       out_duration,
  output logic                              out_accepted,
  output logic                              out_logged,
  output logic [pbdc_pkg::SLOT_IDX_W-1:0]   out_slot_index
);

  pbdc_pkg::cfg_t    cfg;
  pbdc_pkg::result_t res;
  pbdc_pkg::result_t out_res;
  logic              res_push;
  logic              res_free;

  assign cfg_ready = 1'b1;

  pbdc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pbdc_burst_core u_burst_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_edge_seen (in_edge_seen),
    .res_free     (res_free),
    .res_push     (res_push),
    .res          (res)
  );

  pbdc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_duration   = out_res.duration;
  assign out_accepted   = out_res.accepted;
  assign out_logged     = out_res.logged;
  assign out_slot_index = out_res.slot_index;

endmodule
